// File: src/cell_surface_ray_newton_defines.svh
// Assertion macros shared by the checker.
`ifndef CELL_SURFACE_RAY_NEWTON_DEFINES_SVH
`define CELL_SURFACE_RAY_NEWTON_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define CSRN_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define CSRN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: src/csrn_pkg.sv
package csrn_pkg;

	localparam int FracBitsDefault = 25;
	localparam int StepsReset = 10;

	typedef enum logic [2:0] {
		OP_MUL,
		OP_DIV,
		OP_ADD,
		OP_SUB
	} alu_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_WAIT,
		ST_DONE
	} seq_state_t;

	typedef struct packed {
		logic       go;
		alu_op_t    op;
	} alu_req_t;

endpackage

// File: src/csrn_alu.sv
// Shared saturating Q-format unit: multiply (four 32x32 partial products,
// one a cycle), divide (one quotient bit a cycle), add and subtract.
module csrn_alu #(
	parameter int FracBits = csrn_pkg::FracBitsDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  csrn_pkg::alu_req_t  req,
	input  logic signed [63:0]  a,
	input  logic signed [63:0]  b,
	output logic                done,
	output logic signed [63:0]  y
);
	localparam logic [63:0] Smax = 64'h7FFF_FFFF_FFFF_FFFF;

	logic [63:0]  ma_q, mb_q;
	logic         neg_q;
	logic [2:0]   ph_q;
	logic [127:0] acc_q;
	logic [63:0]  rem_q, q_q;
	logic [127:0] num_q;
	logic [7:0]   cnt_q;
	logic         ovf_q;
	logic         busy_q, isdiv_q, dzero_q;
	logic signed [63:0] y_q;
	logic         done_q;

	logic [63:0] mag_a, mag_b;
	logic [31:0] pa, pb;
	logic [63:0] pp;
	logic [63:0] rsh;
	logic [64:0] rsel;
	logic [64:0] sum;
	logic [63:0] mres;
	logic        mov;

	assign mag_a = a[63] ? (~a + 64'd1) : a;
	assign mag_b = b[63] ? (~b + 64'd1) : b;
	assign pa = ph_q[0] ? ma_q[63:32] : ma_q[31:0];
	assign pb = ph_q[1] ? mb_q[63:32] : mb_q[31:0];
	assign pp = {32'd0, pa} * {32'd0, pb};
	assign rsh = {rem_q[62:0], num_q[127]};
	assign rsel = {1'b0, rsh};

	assign mres = 64'(acc_q >> FracBits);
	assign mov = |(acc_q >> (64 + FracBits));

	function automatic logic signed [63:0] sm(input logic n, input logic [63:0] m);
		logic [63:0] c;
		begin
			c = (m > Smax) ? Smax : m;
			sm = n ? -$signed(c) : $signed(c);
		end
	endfunction

	always_comb begin
		sum = {a[63], a} + (req.op == csrn_pkg::OP_SUB ? -{b[63], b} : {b[63], b});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.go && !busy_q) begin
				unique case (req.op)
					csrn_pkg::OP_ADD, csrn_pkg::OP_SUB: begin
						// saturate to the symmetric range
						if (sum[64] != sum[63])
							y_q <= sum[64] ? -$signed(Smax) : $signed(Smax);
						else if (sum[63:0] == 64'h8000_0000_0000_0000)
							y_q <= -$signed(Smax);
						else
							y_q <= $signed(sum[63:0]);
						done_q <= 1'b1;
					end
					csrn_pkg::OP_MUL: begin
						ma_q <= mag_a; mb_q <= mag_b;
						neg_q <= a[63] ^ b[63];
						acc_q <= '0; ph_q <= 3'd0;
						busy_q <= 1'b1; isdiv_q <= 1'b0;
					end
					default: begin
						mb_q <= mag_b;
						neg_q <= a[63] ^ b[63];
						num_q <= {64'd0, mag_a} << FracBits;
						rem_q <= '0; q_q <= '0; ovf_q <= 1'b0;
						cnt_q <= 8'd128;
						dzero_q <= (mag_b == 64'd0);
						busy_q <= 1'b1; isdiv_q <= 1'b1;
					end
				endcase
			end else if (busy_q && !isdiv_q) begin
				if (ph_q == 3'd4) begin
					y_q <= sm(neg_q, mov ? Smax : mres);
					busy_q <= 1'b0; done_q <= 1'b1;
				end else begin
					acc_q <= acc_q + ({64'd0, pp} << (32 * (ph_q[0] + ph_q[1])));
					ph_q <= ph_q + 3'd1;
				end
			end else if (busy_q) begin
				if (dzero_q) begin
					y_q <= (num_q == 128'd0) ? 64'sd0 : sm(neg_q, Smax);
					busy_q <= 1'b0; done_q <= 1'b1;
				end else if (cnt_q == 8'd0) begin
					y_q <= sm(neg_q, ovf_q ? Smax : q_q);
					busy_q <= 1'b0; done_q <= 1'b1;
				end else begin
					num_q <= {num_q[126:0], 1'b0};
					if (rem_q[63] || rsel[63:0] >= mb_q) begin
						rem_q <= rsh - mb_q;
						if (cnt_q > 8'd63) ovf_q <= 1'b1;
						else q_q[cnt_q[5:0] - 6'd1] <= 1'b1;
					end else begin
						rem_q <= rsh;
					end
					cnt_q <= cnt_q - 8'd1;
				end
			end
		end
	end

	assign done = done_q;
	assign y = y_q;
endmodule

// File: src/csrn_seq.sv
// Microcode sequencer: walks a fixed list of ALU operations over a small
// register file, once for each Newton iteration, then a final hit-point list.
module csrn_seq #(
	parameter int FracBits = csrn_pkg::FracBitsDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  logic [4:0]         steps,
	input  logic signed [63:0] s0, s1, s2, v0, v1, v2,
	output csrn_pkg::alu_req_t req,
	output logic signed [63:0] opa,
	output logic signed [63:0] opb,
	input  logic               alu_done,
	input  logic signed [63:0] alu_y,
	output logic               fin,
	output logic signed [63:0] h_out, p0_out, p1_out, p2_out,
	output logic               degen_out
);
	localparam logic signed [63:0] One  = 64'sd1 <<< FracBits;
	localparam logic signed [63:0] Two  = One <<< 1;
	localparam logic signed [63:0] Four = One <<< 2;
	// shape constants, rounded half away from zero
	localparam logic signed [63:0] Ka0 =
		$signed(((64'd518 << FracBits) + 64'd5000) / 64'd10000);
	localparam logic signed [63:0] Ka1 =
		$signed(((64'd20026 << FracBits) + 64'd5000) / 64'd10000);
	localparam logic signed [63:0] Ka2 =
		-$signed(((64'd4491 << FracBits) + 64'd500) / 64'd1000);
	localparam logic signed [63:0] D0sq =
		$signed(((64'd611524 << FracBits) + 64'd5000) / 64'd10000);

	// register file slots
	localparam int RH = 0, RP0 = 1, RP1 = 2, RP2 = 3, RT = 4, RU = 5, RRHO = 6, RSV = 7,
		RG = 8, RF = 9, RDG = 10, RDF = 11, RW = 12;
	localparam int NPC = 6'd49;

	logic signed [63:0] r_q [13];
	logic [5:0] pc_q;
	logic [4:0] k_q;
	csrn_pkg::seq_state_t st_q, st_d;
	logic degen_q;

	typedef struct packed {
		csrn_pkg::alu_op_t op;
		logic [3:0] dst;
	} uop_t;

	uop_t u;
	logic signed [63:0] ua, ub;
	logic last_iter_pc;

	// One micro-op per pc: operands, operation and destination.
	always_comb begin
		u = '{op: csrn_pkg::OP_MUL, dst: 4'(RT)};
		ua = r_q[RH]; ub = v0;
		unique case (pc_q)
			6'd0:  begin u = '{csrn_pkg::OP_MUL, 4'(RT)}; ua = r_q[RH]; ub = v0; end
			6'd1:  begin u = '{csrn_pkg::OP_ADD, 4'(RP0)}; ua = s0; ub = r_q[RT]; end
			6'd2:  begin u = '{csrn_pkg::OP_MUL, 4'(RT)}; ua = r_q[RH]; ub = v1; end
			6'd3:  begin u = '{csrn_pkg::OP_ADD, 4'(RP1)}; ua = s1; ub = r_q[RT]; end
			6'd4:  begin u = '{csrn_pkg::OP_MUL, 4'(RT)}; ua = r_q[RH]; ub = v2; end
			6'd5:  begin u = '{csrn_pkg::OP_ADD, 4'(RP2)}; ua = s2; ub = r_q[RT]; end
			6'd6:  begin u = '{csrn_pkg::OP_MUL, 4'(RT)}; ua = r_q[RP0]; ub = r_q[RP0]; end
			6'd7:  begin u = '{csrn_pkg::OP_MUL, 4'(RU)}; ua = r_q[RP1]; ub = r_q[RP1]; end
			6'd8:  begin u = '{csrn_pkg::OP_ADD, 4'(RT)}; ua = r_q[RT]; ub = r_q[RU]; end
			6'd9:  begin u = '{csrn_pkg::OP_DIV, 4'(RRHO)}; ua = r_q[RT]; ub = D0sq; end
			6'd10: begin u = '{csrn_pkg::OP_MUL, 4'(RT)}; ua = Four; ub = r_q[RRHO]; end
			6'd11: begin u = '{csrn_pkg::OP_SUB, 4'(RSV)}; ua = One; ub = r_q[RT]; end
			6'd12: begin u = '{csrn_pkg::OP_MUL, 4'(RT)}; ua = Ka1; ub = r_q[RRHO]; end
			6'd13: begin u = '{csrn_pkg::OP_ADD, 4'(RG)}; ua = Ka0; ub = r_q[RT]; end
			6'd14: begin u = '{csrn_pkg::OP_MUL, 4'(RT)}; ua = r_q[RRHO]; ub = r_q[RRHO]; end
			6'd15: begin u = '{csrn_pkg::OP_MUL, 4'(RT)}; ua = Ka2; ub = r_q[RT]; end
			6'd16: begin u = '{csrn_pkg::OP_ADD, 4'(RG)}; ua = r_q[RG]; ub = r_q[RT]; end
			6'd17: begin u = '{csrn_pkg::OP_MUL, 4'(RT)}; ua = D0sq; ub = r_q[RSV]; end
			6'd18: begin u = '{csrn_pkg::OP_MUL, 4'(RT)}; ua = r_q[RT]; ub = r_q[RG]; end
			6'd19: begin u = '{csrn_pkg::OP_MUL, 4'(RT)}; ua = r_q[RT]; ub = r_q[RG]; end
			6'd20: begin u = '{csrn_pkg::OP_MUL, 4'(RU)}; ua = r_q[RP2]; ub = r_q[RP2]; end
			6'd21: begin u = '{csrn_pkg::OP_SUB, 4'(RF)}; ua = r_q[RT]; ub = r_q[RU]; end
			6'd22: begin u = '{csrn_pkg::OP_MUL, 4'(RT)}; ua = Two; ub = r_q[RSV]; end
			6'd23: begin u = '{csrn_pkg::OP_MUL, 4'(RU)}; ua = Two; ub = Ka2; end
			6'd24: begin u = '{csrn_pkg::OP_MUL, 4'(RU)}; ua = r_q[RU]; ub = r_q[RRHO]; end
			6'd25: begin u = '{csrn_pkg::OP_ADD, 4'(RU)}; ua = Ka1; ub = r_q[RU]; end
			6'd26: begin u = '{csrn_pkg::OP_MUL, 4'(RT)}; ua = r_q[RT]; ub = r_q[RU]; end
			6'd27: begin u = '{csrn_pkg::OP_MUL, 4'(RT)}; ua = r_q[RT]; ub = r_q[RG]; end
			6'd28: begin u = '{csrn_pkg::OP_MUL, 4'(RU)}; ua = Four; ub = r_q[RG]; end
			6'd29: begin u = '{csrn_pkg::OP_MUL, 4'(RU)}; ua = r_q[RU]; ub = r_q[RG]; end
			6'd30: begin u = '{csrn_pkg::OP_SUB, 4'(RDG)}; ua = r_q[RT]; ub = r_q[RU]; end
			6'd31: begin u = '{csrn_pkg::OP_MUL, 4'(RT)}; ua = Two; ub = r_q[RP0]; end
			6'd32: begin u = '{csrn_pkg::OP_MUL, 4'(RT)}; ua = r_q[RT]; ub = r_q[RDG]; end
			6'd33: begin u = '{csrn_pkg::OP_MUL, 4'(RDF)}; ua = v0; ub = r_q[RT]; end
			6'd34: begin u = '{csrn_pkg::OP_MUL, 4'(RT)}; ua = Two; ub = r_q[RP1]; end
			6'd35: begin u = '{csrn_pkg::OP_MUL, 4'(RT)}; ua = r_q[RT]; ub = r_q[RDG]; end
			6'd36: begin u = '{csrn_pkg::OP_MUL, 4'(RT)}; ua = v1; ub = r_q[RT]; end
			6'd37: begin u = '{csrn_pkg::OP_ADD, 4'(RDF)}; ua = r_q[RDF]; ub = r_q[RT]; end
			6'd38: begin u = '{csrn_pkg::OP_MUL, 4'(RT)}; ua = Two; ub = v2; end
			6'd39: begin u = '{csrn_pkg::OP_MUL, 4'(RT)}; ua = r_q[RT]; ub = r_q[RP2]; end
			6'd40: begin u = '{csrn_pkg::OP_SUB, 4'(RDF)}; ua = r_q[RDF]; ub = r_q[RT]; end
			6'd41: begin u = '{csrn_pkg::OP_DIV, 4'(RW)}; ua = r_q[RF]; ub = r_q[RDF]; end
			6'd42: begin u = '{csrn_pkg::OP_SUB, 4'(RH)}; ua = r_q[RH]; ub = r_q[RW]; end
			// final hit point
			6'd43: begin u = '{csrn_pkg::OP_MUL, 4'(RT)}; ua = r_q[RH]; ub = v0; end
			6'd44: begin u = '{csrn_pkg::OP_ADD, 4'(RP0)}; ua = s0; ub = r_q[RT]; end
			6'd45: begin u = '{csrn_pkg::OP_MUL, 4'(RT)}; ua = r_q[RH]; ub = v1; end
			6'd46: begin u = '{csrn_pkg::OP_ADD, 4'(RP1)}; ua = s1; ub = r_q[RT]; end
			6'd47: begin u = '{csrn_pkg::OP_MUL, 4'(RT)}; ua = r_q[RH]; ub = v2; end
			6'd48: begin u = '{csrn_pkg::OP_ADD, 4'(RP2)}; ua = s2; ub = r_q[RT]; end
			default: begin u = '{csrn_pkg::OP_ADD, 4'(RT)}; ua = r_q[RT]; ub = '0; end
		endcase
	end

	assign last_iter_pc = (pc_q == 6'd42);

	always_comb begin
		st_d = st_q;
		req = '{go: 1'b0, op: u.op};
		unique case (st_q)
			csrn_pkg::ST_IDLE: if (go) st_d = csrn_pkg::ST_RUN;
			csrn_pkg::ST_RUN: begin
				req.go = 1'b1;
				st_d = csrn_pkg::ST_WAIT;
			end
			csrn_pkg::ST_WAIT: if (alu_done) begin
				if (pc_q == 6'(NPC - 1)) st_d = csrn_pkg::ST_DONE;
				else st_d = csrn_pkg::ST_RUN;
			end
			csrn_pkg::ST_DONE: st_d = csrn_pkg::ST_IDLE;
			default: st_d = csrn_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= csrn_pkg::ST_IDLE;
			pc_q <= '0;
			k_q <= '0;
			degen_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == csrn_pkg::ST_IDLE && go) begin
				r_q[RH] <= '0;
				degen_q <= 1'b0;
				k_q <= 5'd0;
				// no iterations: go straight to the hit point
				pc_q <= (steps == 5'd0) ? 6'd43 : 6'd0;
			end else if (st_q == csrn_pkg::ST_WAIT && alu_done) begin
				r_q[u.dst] <= alu_y;
				if (pc_q == 6'd40 && alu_y == 64'sd0) begin
					degen_q <= 1'b1;
					pc_q <= 6'd43;
				end else if (last_iter_pc) begin
					k_q <= k_q + 5'd1;
					pc_q <= (k_q + 5'd1 == steps) ? 6'd43 : 6'd0;
				end else begin
					pc_q <= pc_q + 6'd1;
				end
			end
		end
	end

	assign opa = ua;
	assign opb = ub;
	assign fin = (st_q == csrn_pkg::ST_DONE);
	assign h_out = r_q[RH];
	assign p0_out = r_q[RP0];
	assign p1_out = r_q[RP1];
	assign p2_out = r_q[RP2];
	assign degen_out = degen_q;
endmodule

// File: src/cell_surface_ray_newton.sv
// Channel     | Signals                                   | Handshake
// ------------+-------------------------------------------+---------------------------
// segment in  | start_x..z, end_x..z                      | start & !busy
// result out  | step_fraction, hit_x..z, degenerate       | done strobe, one cycle
// config      | cfg_we, cfg_wdata (newton_steps)          | cfg_we, no wait
//
// Schedule: one shared unit runs 43 micro-operations per Newton step: 28
// multiplies, 13 adds and 2 divides (one quotient bit a cycle, the dominant
// cost), then the hit point; a zero derivative cuts the run short.
// Reset clears the sequencer and sets newton_steps to 10. The receiver cannot
// stall; busy stays high from acceptance to the done strobe.
module cell_surface_ray_newton #(
	parameter int FracBits = csrn_pkg::FracBitsDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] start_x,
	input  logic signed [31:0] start_y,
	input  logic signed [31:0] start_z,
	input  logic signed [31:0] end_x,
	input  logic signed [31:0] end_y,
	input  logic signed [31:0] end_z,
	input  logic               cfg_we,
	input  logic [4:0]         cfg_wdata,
	output logic               done,
	output logic signed [31:0] step_fraction,
	output logic signed [31:0] hit_x,
	output logic signed [31:0] hit_y,
	output logic signed [31:0] hit_z,
	output logic               degenerate
);
	logic [4:0] steps_q;
	logic busy_q;
	logic signed [63:0] s0_q, s1_q, s2_q, v0_q, v1_q, v2_q;
	csrn_pkg::alu_req_t req;
	logic signed [63:0] opa, opb, alu_y, h, p0, p1, p2;
	logic alu_done, fin, degen;
	logic accept;

	assign accept = start && !busy_q;

	// Clamp a 64-bit value to the 32-bit result range.
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		begin
			if (v > 64'sd2147483647) sat32 = 32'sh7FFF_FFFF;
			else if (v < -64'sd2147483648) sat32 = 32'sh8000_0000;
			else sat32 = v[31:0];
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q <= 5'(csrn_pkg::StepsReset);
			busy_q <= 1'b0;
		end else begin
			if (cfg_we) steps_q <= cfg_wdata;
			if (accept) busy_q <= 1'b1;
			else if (fin) busy_q <= 1'b0;
		end
	end

	// Hold the segment: start point and direction, widened to 64 bits.
	always_ff @(posedge clk) begin
		if (accept) begin
			s0_q <= 64'(start_x); s1_q <= 64'(start_y); s2_q <= 64'(start_z);
			v0_q <= 64'(end_x) - 64'(start_x);
			v1_q <= 64'(end_y) - 64'(start_y);
			v2_q <= 64'(end_z) - 64'(start_z);
		end
	end

	csrn_seq #(.FracBits(FracBits)) u_seq (
		.clk, .arst_n, .go(accept), .steps(steps_q),
		.s0(s0_q), .s1(s1_q), .s2(s2_q), .v0(v0_q), .v1(v1_q), .v2(v2_q),
		.req, .opa, .opb, .alu_done, .alu_y,
		.fin, .h_out(h), .p0_out(p0), .p1_out(p1), .p2_out(p2), .degen_out(degen)
	);

	csrn_alu #(.FracBits(FracBits)) u_alu (
		.clk, .arst_n, .req, .a(opa), .b(opb), .done(alu_done), .y(alu_y)
	);

	assign busy = busy_q;
	assign done = fin;
	assign step_fraction = sat32(h);
	assign hit_x = sat32(p0);
	assign hit_y = sat32(p1);
	assign hit_z = sat32(p2);
	assign degenerate = degen;
endmodule

// File: src/csrn_checker.sv
`include "cell_surface_ray_newton_defines.svh"

module csrn_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);
	`CSRN_ASSERT_NEXT(a_acc_busy, clk, arst_n, start && !busy, busy)
	`CSRN_ASSERT_IMPL(a_done_busy, clk, arst_n, done, busy)
	`CSRN_ASSERT_NEXT(a_done_one, clk, arst_n, done, !done)
	`CSRN_ASSERT_NEXT(a_done_free, clk, arst_n, done, !busy)
endmodule

bind cell_surface_ray_newton csrn_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done)
);
